FILE: rtl/core/lswap_pkg.sv
// Shared types and constants of the LIFO stack with swap.
package lswap_pkg;

  localparam int WORD_W  = 32;
  localparam int INDEX_W = 8;

  // Request operation codes
  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2,
    OP_SWAP = 2'd3
  } lswap_op_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WRITE2
  } lswap_state_t;

endpackage

FILE: rtl/core/lswap_mem.sv
// Entry store: two synchronous read ports, one write port.
module lswap_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                              clk,
  input  logic                              rd_en,
  input  logic [AW-1:0]                     rd_addr_a,
  input  logic [AW-1:0]                     rd_addr_b,
  output logic signed [lswap_pkg::WORD_W-1:0] rd_data_a,
  output logic signed [lswap_pkg::WORD_W-1:0] rd_data_b,
  input  logic                              wr_en,
  input  logic [AW-1:0]                     wr_addr,
  input  logic signed [lswap_pkg::WORD_W-1:0] wr_data
);

  logic signed [lswap_pkg::WORD_W-1:0] mem [DEPTH];
  logic signed [lswap_pkg::WORD_W-1:0] rd_data_a_r;
  logic signed [lswap_pkg::WORD_W-1:0] rd_data_b_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read ports, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a_r <= mem[rd_addr_a];
      rd_data_b_r <= mem[rd_addr_b];
    end
  end

  assign rd_data_a = rd_data_a_r;
  assign rd_data_b = rd_data_b_r;

endmodule

FILE: rtl/core/lswap_ctrl.sv
// Request sequencer: fill count, range checks, memory access and result register.
module lswap_ctrl #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int CW    = 9
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_operation,
  input  logic signed [lswap_pkg::WORD_W-1:0] in_push_value,
  input  logic [lswap_pkg::INDEX_W-1:0]       in_first_index,
  input  logic [lswap_pkg::INDEX_W-1:0]       in_second_index,
  output logic                                out_strobe,
  output logic                                out_success,
  output logic signed [lswap_pkg::WORD_W-1:0] out_read_value,
  output logic                                out_now_empty,
  output logic                                rd_en,
  output logic [AW-1:0]                       rd_addr_a,
  output logic [AW-1:0]                       rd_addr_b,
  input  logic signed [lswap_pkg::WORD_W-1:0] rd_data_a,
  input  logic signed [lswap_pkg::WORD_W-1:0] rd_data_b,
  output logic                                wr_en,
  output logic [AW-1:0]                       wr_addr,
  output logic signed [lswap_pkg::WORD_W-1:0] wr_data
);

  localparam int CMPW = (CW > lswap_pkg::INDEX_W) ? CW : lswap_pkg::INDEX_W;

  lswap_pkg::lswap_state_t state_r, state_nxt;
  lswap_pkg::lswap_op_t    op_r, op_nxt;
  lswap_pkg::lswap_op_t    op_in;
  logic [CW-1:0]           fill_r, fill_nxt;
  logic [AW-1:0]           sa_r, sa_nxt;
  logic [AW-1:0]           sb_r, sb_nxt;
  logic                    out_strobe_r, out_strobe_nxt;
  logic                    out_success_r, out_success_nxt;
  logic signed [lswap_pkg::WORD_W-1:0] out_read_value_r, out_read_value_nxt;
  logic                    out_now_empty_r, out_now_empty_nxt;

  logic                    accept;
  logic                    is_empty;
  logic                    is_full;
  logic [CMPW-1:0]         fill_ext;
  logic [CMPW-1:0]         a_ext;
  logic [CMPW-1:0]         b_ext;
  logic [CMPW-1:0]         top_full;
  logic [CMPW-1:0]         sa_full;
  logic [CMPW-1:0]         sb_full;
  logic                    out_of_range;

  assign accept   = start && (state_r == lswap_pkg::ST_IDLE);
  assign op_in    = lswap_pkg::lswap_op_t'(in_operation);
  assign is_empty = (fill_r == '0);
  assign is_full  = (fill_r == CW'(DEPTH));

  // Positions from the top turned into slot addresses
  assign fill_ext     = CMPW'(fill_r);
  assign a_ext        = CMPW'(in_first_index);
  assign b_ext        = CMPW'(in_second_index);
  assign top_full     = fill_ext - CMPW'(1);
  assign sa_full      = top_full - a_ext;
  assign sb_full      = top_full - b_ext;
  assign out_of_range = (a_ext >= fill_ext) || (b_ext >= fill_ext);

  // Next state, memory access and result
  always_comb begin
    state_nxt          = state_r;
    op_nxt             = op_r;
    fill_nxt           = fill_r;
    sa_nxt             = sa_r;
    sb_nxt             = sb_r;
    out_strobe_nxt     = 1'b0;
    out_success_nxt    = out_success_r;
    out_read_value_nxt = out_read_value_r;
    out_now_empty_nxt  = out_now_empty_r;
    rd_en              = 1'b0;
    rd_addr_a          = top_full[AW-1:0];
    rd_addr_b          = top_full[AW-1:0];
    wr_en              = 1'b0;
    wr_addr            = fill_r[AW-1:0];
    wr_data            = in_push_value;

    unique case (state_r)
      lswap_pkg::ST_IDLE: begin
        if (accept) begin
          op_nxt             = op_in;
          out_read_value_nxt = '0;
          out_success_nxt    = 1'b0;
          unique case (op_in)
            lswap_pkg::OP_PUSH: begin
              out_strobe_nxt = 1'b1;
              if (!is_full) begin
                wr_en           = 1'b1;
                fill_nxt        = fill_r + CW'(1);
                out_success_nxt = 1'b1;
              end
              out_now_empty_nxt = (fill_nxt == '0);
            end
            lswap_pkg::OP_POP, lswap_pkg::OP_PEEK: begin
              if (is_empty) begin
                out_strobe_nxt    = 1'b1;
                out_now_empty_nxt = 1'b1;
              end else begin
                rd_en     = 1'b1;
                state_nxt = lswap_pkg::ST_READ;
                if (op_in == lswap_pkg::OP_POP) begin
                  fill_nxt = fill_r - CW'(1);
                end
              end
            end
            lswap_pkg::OP_SWAP: begin
              out_now_empty_nxt = is_empty;
              if (is_empty) begin
                out_strobe_nxt = 1'b1;
              end else if (in_first_index == in_second_index) begin
                out_strobe_nxt  = 1'b1;
                out_success_nxt = 1'b1;
              end else if (out_of_range) begin
                out_strobe_nxt = 1'b1;
              end else begin
                rd_en     = 1'b1;
                rd_addr_a = sa_full[AW-1:0];
                rd_addr_b = sb_full[AW-1:0];
                sa_nxt    = sa_full[AW-1:0];
                sb_nxt    = sb_full[AW-1:0];
                state_nxt = lswap_pkg::ST_READ;
              end
            end
            default: ;
          endcase
        end
      end
      lswap_pkg::ST_READ: begin
        if (op_r == lswap_pkg::OP_SWAP) begin
          // first half of the exchange
          wr_en     = 1'b1;
          wr_addr   = sa_r;
          wr_data   = rd_data_b;
          state_nxt = lswap_pkg::ST_WRITE2;
        end else begin
          // pop or peek: deliver the top word
          out_strobe_nxt     = 1'b1;
          out_success_nxt    = 1'b1;
          out_read_value_nxt = rd_data_a;
          out_now_empty_nxt  = is_empty;
          state_nxt          = lswap_pkg::ST_IDLE;
        end
      end
      lswap_pkg::ST_WRITE2: begin
        // second half of the exchange
        wr_en             = 1'b1;
        wr_addr           = sb_r;
        wr_data           = rd_data_a;
        out_strobe_nxt    = 1'b1;
        out_success_nxt   = 1'b1;
        out_now_empty_nxt = is_empty;
        state_nxt         = lswap_pkg::ST_IDLE;
      end
      default: state_nxt = lswap_pkg::ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lswap_pkg::ST_IDLE;
      fill_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Payload and request context
  always_ff @(posedge clk) begin
    op_r             <= op_nxt;
    sa_r             <= sa_nxt;
    sb_r             <= sb_nxt;
    out_success_r    <= out_success_nxt;
    out_read_value_r <= out_read_value_nxt;
    out_now_empty_r  <= out_now_empty_nxt;
  end

  assign busy           = (state_r != lswap_pkg::ST_IDLE);
  assign out_strobe     = out_strobe_r;
  assign out_success    = out_success_r;
  assign out_read_value = out_read_value_r;
  assign out_now_empty  = out_now_empty_r;

endmodule

FILE: rtl/core/lifo_stack_with_swap.sv
// Top level of the LIFO stack with swap.
//
//   channel | ports                                        | handshake
//   --------+----------------------------------------------+----------------------------
//   request | in_operation, in_push_value, in_first_index, | taken when start && !busy
//           | in_second_index                              |
//   result  | out_success, out_read_value, out_now_empty   | one cycle, marked out_strobe
//
// Push and every failing or trivially succeeding request is answered from idle: the
// result shows on the next cycle and busy stays low. Pop and peek go through ST_READ
// while the entry store reads the top word; a swap also goes through ST_WRITE2, as
// the entry store's single write port writes the exchanged words one after the other.
// Reset empties the stack at once; the entry store itself is not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module lifo_stack_with_swap #(
  parameter int DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_operation,
  input  logic signed [lswap_pkg::WORD_W-1:0] in_push_value,
  input  logic [lswap_pkg::INDEX_W-1:0]       in_first_index,
  input  logic [lswap_pkg::INDEX_W-1:0]       in_second_index,
  output logic                                out_strobe,
  output logic                                out_success,
  output logic signed [lswap_pkg::WORD_W-1:0] out_read_value,
  output logic                                out_now_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic                                rd_en;
  logic [AW-1:0]                       rd_addr_a;
  logic [AW-1:0]                       rd_addr_b;
  logic signed [lswap_pkg::WORD_W-1:0] rd_data_a;
  logic signed [lswap_pkg::WORD_W-1:0] rd_data_b;
  logic                                wr_en;
  logic [AW-1:0]                       wr_addr;
  logic signed [lswap_pkg::WORD_W-1:0] wr_data;

  // Sequencer
  lswap_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_push_value   (in_push_value),
    .in_first_index  (in_first_index),
    .in_second_index (in_second_index),
    .out_strobe      (out_strobe),
    .out_success     (out_success),
    .out_read_value  (out_read_value),
    .out_now_empty   (out_now_empty),
    .rd_en           (rd_en),
    .rd_addr_a       (rd_addr_a),
    .rd_addr_b       (rd_addr_b),
    .rd_data_a       (rd_data_a),
    .rd_data_b       (rd_data_b),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data)
  );

  // Entry store
  lswap_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk       (clk),
    .rd_en     (rd_en),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

endmodule

FILE: rtl/core/lswap_checker.sv
// Port-level checks on the LIFO stack with swap, bound to the top level.
module lswap_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic [1:0]                          in_operation,
  input logic                                out_strobe,
  input logic                                out_success,
  input logic signed [lswap_pkg::WORD_W-1:0] out_read_value,
  input logic                                out_now_empty
);

  logic accept;
  assign accept = start && !busy;

  // Reset leaves no result pending and the block idle
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_strobe && !busy)
    else $error("result or busy after reset");

  // A request either answers at once or holds busy, never both
  a_answer_or_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (out_strobe != busy))
    else $error("request neither answered nor held busy");

  // A push answers on the next cycle and leaves the stack non-empty when it lands
  a_push_answer: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_operation == lswap_pkg::OP_PUSH)
      |=> out_strobe && (!out_success || !out_now_empty))
    else $error("push answer missing or wrong");

  // A failed request returns a zero word
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_success |-> (out_read_value == '0))
    else $error("failed request returned a word");

endmodule

bind lifo_stack_with_swap lswap_checker u_lswap_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_operation   (in_operation),
  .out_strobe     (out_strobe),
  .out_success    (out_success),
  .out_read_value (out_read_value),
  .out_now_empty  (out_now_empty)
);

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the LIFO stack with swap: directed table, then random bursts.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STACK_DEPTH   = 256;
  localparam int RANDOM_ITEMS  = 1800;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 10;

  typedef logic signed [lswap_pkg::WORD_W-1:0] word_t;
  typedef logic [lswap_pkg::INDEX_W-1:0]       index_t;

  typedef struct packed {
    logic  success;
    word_t read_value;
    logic  now_empty;
  } stack_result_t;

  typedef struct {
    lswap_pkg::lswap_op_t op;
    word_t                value;
    index_t               first;
    index_t               second;
    bit                   typed;
    stack_result_t        res;
  } request_t;

  typedef enum int {BURST_MIXED, BURST_FILL, BURST_DRAIN} burst_kind_t;

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic [1:0]                 in_operation;
  word_t                      in_push_value;
  index_t                     in_first_index;
  index_t                     in_second_index;
  logic                       out_strobe;
  logic                       out_success;
  word_t                      out_read_value;
  logic                       out_now_empty;

  // Typed expectation travelling with the request on the bus
  logic                       req_typed;
  stack_result_t              req_typed_res;

  // Shadow copy of the stack contents
  word_t                      shadow_words [STACK_DEPTH];
  int                         shadow_fill;

  stack_result_t              pending_results [$];
  request_t                   directed_rows [$];
  int                         error_count;
  int                         cycle_count;

  lifo_stack_with_swap #(.DEPTH(STACK_DEPTH)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_push_value   (in_push_value),
    .in_first_index  (in_first_index),
    .in_second_index (in_second_index),
    .out_strobe      (out_strobe),
    .out_success     (out_success),
    .out_read_value  (out_read_value),
    .out_now_empty   (out_now_empty)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Apply one request to the shadow stack and return its result
  function automatic stack_result_t apply_request(lswap_pkg::lswap_op_t op, word_t value,
                                                  index_t first, index_t second);
    stack_result_t r;
    int slot_a;
    int slot_b;
    word_t held;
    r.success    = 1'b0;
    r.read_value = '0;
    case (op)
      lswap_pkg::OP_PUSH: begin
        if (shadow_fill < STACK_DEPTH) begin
          shadow_words[shadow_fill] = value;
          shadow_fill++;
          r.success = 1'b1;
        end
      end
      lswap_pkg::OP_POP: begin
        if (shadow_fill != 0) begin
          r.read_value = shadow_words[shadow_fill-1];
          shadow_fill--;
          r.success = 1'b1;
        end
      end
      lswap_pkg::OP_PEEK: begin
        if (shadow_fill != 0) begin
          r.read_value = shadow_words[shadow_fill-1];
          r.success = 1'b1;
        end
      end
      default: begin
        if (shadow_fill != 0) begin
          if (first == second) begin
            r.success = 1'b1;
          end else if (int'(first) < shadow_fill && int'(second) < shadow_fill) begin
            slot_a = shadow_fill - 1 - int'(first);
            slot_b = shadow_fill - 1 - int'(second);
            held = shadow_words[slot_a];
            shadow_words[slot_a] = shadow_words[slot_b];
            shadow_words[slot_b] = held;
            r.success = 1'b1;
          end
        end
      end
    endcase
    r.now_empty = (shadow_fill == 0);
    return r;
  endfunction

  // Record accepted requests and check each strobed result
  always @(posedge clk) begin
    stack_result_t predicted;
    stack_result_t want;
    if (rst_n) begin
      if (out_strobe) begin
        if (pending_results.size() == 0) begin
          $error("result strobed with no request outstanding");
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_success !== want.success) begin
            $error("success: expected %0d, got %0d", want.success, out_success);
            error_count++;
          end
          if (out_read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value, out_read_value);
            error_count++;
          end
          if (out_now_empty !== want.now_empty) begin
            $error("now_empty: expected %0d, got %0d", want.now_empty, out_now_empty);
            error_count++;
          end
        end
      end
      if (start && !busy) begin
        predicted = apply_request(lswap_pkg::lswap_op_t'(in_operation), in_push_value,
                                  in_first_index, in_second_index);
        pending_results.push_back(req_typed ? req_typed_res : predicted);
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Build one directed row
  task automatic add_row(lswap_pkg::lswap_op_t op, word_t value,
                         index_t first, index_t second,
                         bit typed, logic ok, word_t rd, logic empty);
    request_t rq;
    rq.op     = op;
    rq.value  = value;
    rq.first  = first;
    rq.second = second;
    rq.typed  = typed;
    rq.res    = '{ok, rd, empty};
    directed_rows.push_back(rq);
  endtask

  // Present one request at the falling edge and hold it until taken
  task automatic send_request(request_t rq);
    in_operation    <= rq.op;
    in_push_value   <= rq.value;
    in_first_index  <= rq.first;
    in_second_index <= rq.second;
    req_typed       <= rq.typed;
    req_typed_res   <= rq.res;
    start           <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Drop start and idle for a number of cycles; zero keeps requests back to back
  task automatic idle_for(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  // Drop start and hold off until every outstanding result has come
  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  function automatic word_t random_word();
    case ($urandom_range(0, 15))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return 32'sd0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Generate one random request of the given burst kind
  function automatic request_t make_request(burst_kind_t kind);
    request_t rq;
    int pick;
    rq.value  = random_word();
    rq.first  = index_t'($urandom_range(0, 255));
    rq.second = index_t'($urandom_range(0, 255));
    rq.typed  = 1'b0;
    rq.res    = '0;
    if (kind == BURST_FILL) begin
      rq.op = lswap_pkg::OP_PUSH;
    end else if (kind == BURST_DRAIN) begin
      rq.op = lswap_pkg::OP_POP;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 33)      rq.op = lswap_pkg::OP_PUSH;
      else if (pick < 58) rq.op = lswap_pkg::OP_POP;
      else if (pick < 72) rq.op = lswap_pkg::OP_PEEK;
      else                rq.op = lswap_pkg::OP_SWAP;
      if (rq.op == lswap_pkg::OP_SWAP && shadow_fill > 0) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          rq.second = rq.first;
        end else if (pick > 2) begin
          rq.first  = index_t'($urandom_range(0, shadow_fill - 1));
          rq.second = index_t'($urandom_range(0, shadow_fill - 1));
        end
      end
    end
    return rq;
  endfunction

  initial begin
    burst_kind_t kind;
    int sent;
    int len;
    int pick;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_operation    = lswap_pkg::OP_PUSH;
    in_push_value   = '0;
    in_first_index  = '0;
    in_second_index = '0;
    req_typed       = 1'b0;
    req_typed_res   = '0;
    shadow_fill     = 0;
    error_count     = 0;
    cycle_count     = 0;

    // Directed rows: empty-stack errors, word extremes, swap cases
    add_row(lswap_pkg::OP_POP,  32'sd0,  8'd0,   8'd0,   1'b1, 1'b0, 32'sd0,  1'b1);
    add_row(lswap_pkg::OP_PEEK, 32'sd5,  8'd0,   8'd0,   1'b1, 1'b0, 32'sd0,  1'b1);
    add_row(lswap_pkg::OP_SWAP, 32'sd0,  8'd0,   8'd0,   1'b1, 1'b0, 32'sd0,  1'b1);
    add_row(lswap_pkg::OP_SWAP, -32'sd1, 8'd255, 8'd255, 1'b1, 1'b0, 32'sd0,  1'b1);
    add_row(lswap_pkg::OP_SWAP, 32'sd0,  8'd0,   8'd255, 1'b1, 1'b0, 32'sd0,  1'b1);
    add_row(lswap_pkg::OP_PUSH, 32'sh7fffffff, 8'd255, 8'd0, 1'b1, 1'b1, 32'sd0, 1'b0);
    add_row(lswap_pkg::OP_PUSH, 32'sh80000000, 8'd0, 8'd255, 1'b1, 1'b1, 32'sd0, 1'b0);
    add_row(lswap_pkg::OP_PUSH, 32'sd0,  8'd0,   8'd0,   1'b1, 1'b1, 32'sd0,  1'b0);
    add_row(lswap_pkg::OP_PUSH, -32'sd1, 8'd0,   8'd0,   1'b1, 1'b1, 32'sd0,  1'b0);
    add_row(lswap_pkg::OP_PEEK, 32'sd0,  8'd0,   8'd0,   1'b1, 1'b1, -32'sd1, 1'b0);
    add_row(lswap_pkg::OP_SWAP, 32'sd0,  8'd0,   8'd3,   1'b1, 1'b1, 32'sd0,  1'b0);
    add_row(lswap_pkg::OP_PEEK, 32'sd0,  8'd0,   8'd0,   1'b0, 1'b0, 32'sd0,  1'b0);
    add_row(lswap_pkg::OP_SWAP, 32'sd0,  8'd2,   8'd2,   1'b1, 1'b1, 32'sd0,  1'b0);
    add_row(lswap_pkg::OP_SWAP, 32'sd0,  8'd255, 8'd255, 1'b1, 1'b1, 32'sd0,  1'b0);
    add_row(lswap_pkg::OP_SWAP, 32'sd0,  8'd0,   8'd4,   1'b1, 1'b0, 32'sd0,  1'b0);
    add_row(lswap_pkg::OP_SWAP, 32'sd0,  8'd255, 8'd0,   1'b1, 1'b0, 32'sd0,  1'b0);
    add_row(lswap_pkg::OP_SWAP, 32'sd0,  8'd1,   8'd2,   1'b0, 1'b0, 32'sd0,  1'b0);
    add_row(lswap_pkg::OP_POP,  32'sd0,  8'd0,   8'd0,   1'b0, 1'b0, 32'sd0,  1'b0);
    add_row(lswap_pkg::OP_PEEK, 32'sd0,  8'd0,   8'd0,   1'b0, 1'b0, 32'sd0,  1'b0);
    add_row(lswap_pkg::OP_POP,  32'sd0,  8'd0,   8'd0,   1'b0, 1'b0, 32'sd0,  1'b0);
    add_row(lswap_pkg::OP_POP,  32'sd0,  8'd0,   8'd0,   1'b0, 1'b0, 32'sd0,  1'b0);
    add_row(lswap_pkg::OP_POP,  32'sd0,  8'd0,   8'd0,   1'b0, 1'b0, 32'sd0,  1'b0);
    add_row(lswap_pkg::OP_POP,  32'sh7fffffff, 8'd0, 8'd0, 1'b1, 1'b0, 32'sd0, 1'b1);

    // Hold reset, then release at a falling edge
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Walk the directed table with occasional gaps
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i]);
      if ($urandom_range(0, 2) == 0) idle_for(int'($urandom_range(1, 3)));
    end
    wait_drained();

    // Random bursts: first fill the stack to beyond full, then mix
    sent = 0;
    kind = BURST_FILL;
    while (sent < RANDOM_ITEMS) begin
      if (kind == BURST_FILL) begin
        len = STACK_DEPTH - shadow_fill + int'($urandom_range(1, 4));
      end else if (kind == BURST_DRAIN) begin
        len = shadow_fill + int'($urandom_range(1, 4));
      end else begin
        len = int'($urandom_range(1, 40));
      end
      for (int k = 0; k < len; k++) begin
        send_request(make_request(kind));
        sent++;
      end
      pick = $urandom_range(0, 19);
      if (pick == 0)      wait_drained();
      else if (pick < 8)  idle_for(0);
      else                idle_for(int'($urandom_range(1, 8)));
      pick = $urandom_range(0, 99);
      if (pick < 4)       kind = BURST_FILL;
      else if (pick < 8)  kind = BURST_DRAIN;
      else                kind = BURST_MIXED;
    end

    // Let the last results arrive, then report
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/lswap_pkg.sv
rtl/core/lswap_mem.sv
rtl/core/lswap_ctrl.sv
rtl/core/lifo_stack_with_swap.sv
rtl/core/lswap_checker.sv
tb/sv/tb_top.sv
